/* design/pcip_pkg.sv */
// Package for the polygon chunk index parser.
// Field widths, configuration register codes and the result record type.
// No dependencies; every other design file imports this package.
package pcip_pkg;

  localparam int unsigned WordW       = 16;
  localparam int unsigned ChunkBytesW = 32;
  localparam int unsigned KindW       = 2;
  localparam int unsigned ValueW      = 24;
  localparam int unsigned FlagsW      = 6;
  localparam int unsigned CountW      = 10;
  localparam int unsigned PolyNumW    = 16;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [ChunkBytesW-1:0] ChunkBytesReset = 32'd4;
  localparam logic [7:0]             LongMark        = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgChunkBytes = 1'b0,
    CfgPolyKind   = 1'b1
  } pcip_cfg_idx_e;

  // Chunk kinds
  typedef enum logic [KindW-1:0] {
    KindFace = 2'd0,
    KindBone = 2'd1,
    KindSkip = 2'd2,
    KindRsvd = 2'd3
  } pcip_kind_e;

  // Record kinds
  typedef enum logic {
    RecHeader = 1'b0,
    RecVertex = 1'b1
  } pcip_rec_e;

  typedef struct packed {
    logic [ChunkBytesW-1:0] chunk_bytes;
    logic [KindW-1:0]       poly_kind;
  } pcip_cfg_t;

  typedef struct packed {
    logic                record_kind;
    logic [ValueW-1:0]   value;
    logic [FlagsW-1:0]   poly_flags;
    logic [CountW-1:0]   vertex_slot;
    logic [PolyNumW-1:0] polygon_number;
    logic                is_bone;
    logic                last_in_chunk;
    logic                status;
  } pcip_res_t;

endpackage

/* design/pcip_if.sv */
// Stream interfaces for the polygon chunk index parser: word input and record output.
// Each carries valid, ready and payload. Depends on pcip_pkg.
interface pcip_in_if;
  import pcip_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface pcip_out_if;
  import pcip_pkg::*;

  logic                valid;
  logic                ready;
  logic                record_kind;
  logic [ValueW-1:0]   value;
  logic [FlagsW-1:0]   poly_flags;
  logic [CountW-1:0]   vertex_slot;
  logic [PolyNumW-1:0] polygon_number;
  logic                is_bone;
  logic                last_in_chunk;
  logic                status;

  modport source (
    output valid, output record_kind, output value, output poly_flags,
    output vertex_slot, output polygon_number, output is_bone,
    output last_in_chunk, output status, input ready
  );
  modport sink (
    input valid, input record_kind, input value, input poly_flags,
    input vertex_slot, input polygon_number, input is_bone,
    input last_in_chunk, input status, output ready
  );
endinterface

/* design/pcip_in_stage.sv */
// Input register of the parser: holds one accepted word until it is processed.
// Depends on pcip_pkg and pcip_in_if.
module pcip_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  pcip_in_if.sink                 in_if,
  input  logic                    proc_en_i,
  output logic                    word_valid_o,
  output logic [pcip_pkg::WordW-1:0] word_o
);
  import pcip_pkg::*;

  logic             valid_q, valid_d;
  logic [WordW-1:0] word_q;
  logic             accept;

  // Take a new word when empty or when the held word moves on this cycle
  assign in_if.ready = !valid_q || proc_en_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (proc_en_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_if.data_word;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

/* design/pcip_parser.sv */
// Parse state and record decode: byte count, vertex count, slot, long-index half
// and polygon counter, updated once per processed word. Depends on pcip_pkg.
module pcip_parser #(
  parameter int unsigned POLY_COUNT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       proc_en_i,
  input  logic [pcip_pkg::WordW-1:0] word_i,
  input  pcip_pkg::pcip_cfg_t        cfg_i,
  output logic                       res_valid_o,
  output pcip_pkg::pcip_res_t        res_o
);
  import pcip_pkg::*;

  logic [ChunkBytesW-1:0]     bytes_seen_q, bytes_seen_d;
  logic [CountW-1:0]          vleft_q, vleft_d;
  logic [CountW-1:0]          slot_q, slot_d;
  logic [7:0]                 high_half_q, high_half_d;
  logic                       high_pend_q, high_pend_d;
  logic [POLY_COUNT_BITS-1:0] poly_cnt_q, poly_cnt_d;
  logic                       chunk_done_q, chunk_done_d;

  logic [ChunkBytesW:0]   bytes_sum;
  logic [ChunkBytesW-1:0] bytes_next;
  logic                   done_now;
  logic                   last;
  logic [CountW-1:0]      vleft_dec;
  logic [CountW-1:0]      count;
  logic [PolyNumW-1:0]    poly_num;

  // Saturating byte count and end-of-chunk compare
  assign bytes_sum  = {1'b0, bytes_seen_q} + (ChunkBytesW+1)'(2);
  assign bytes_next = bytes_sum[ChunkBytesW] ? '1 : bytes_sum[ChunkBytesW-1:0];
  assign done_now   = chunk_done_q || (bytes_seen_q >= cfg_i.chunk_bytes);
  assign last       = bytes_next >= cfg_i.chunk_bytes;
  assign vleft_dec  = vleft_q - CountW'(1);
  assign count      = word_i[CountW-1:0];

  // Reported polygon number saturates at the field width
  if (POLY_COUNT_BITS > PolyNumW) begin : g_pn_sat
    assign poly_num = (|poly_cnt_d[POLY_COUNT_BITS-1:PolyNumW]) ?
                      '1 : poly_cnt_d[PolyNumW-1:0];
  end else begin : g_pn_ext
    assign poly_num = PolyNumW'(poly_cnt_d);
  end

  // Next state and result record
  always_comb begin
    bytes_seen_d = bytes_seen_q;
    vleft_d      = vleft_q;
    slot_d       = slot_q;
    high_half_d  = high_half_q;
    high_pend_d  = high_pend_q;
    poly_cnt_d   = poly_cnt_q;
    chunk_done_d = chunk_done_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (proc_en_i) begin
      if (done_now) begin
        chunk_done_d = 1'b1;
      end else begin
        bytes_seen_d = bytes_next;
        chunk_done_d = last;
        if (!cfg_i.poly_kind[1]) begin
          if (high_pend_q) begin
            // Second half of a long index
            high_pend_d       = 1'b0;
            vleft_d           = vleft_dec;
            slot_d            = slot_q + CountW'(1);
            res_valid_o       = 1'b1;
            res_o.record_kind = RecVertex;
            res_o.value       = {high_half_q, word_i};
            res_o.vertex_slot = slot_q;
            res_o.status      = last && (vleft_dec != '0);
          end else if (vleft_q != '0) begin
            if (word_i[WordW-1 -: 8] == LongMark) begin
              // First half of a long index; shown only if the chunk ends here
              high_half_d = word_i[7:0];
              high_pend_d = 1'b1;
              if (last) begin
                res_valid_o       = 1'b1;
                res_o.record_kind = RecVertex;
                res_o.value       = {word_i[7:0], 16'h0000};
                res_o.vertex_slot = slot_q;
                res_o.status      = 1'b1;
              end
            end else begin
              // Short index
              vleft_d           = vleft_dec;
              slot_d            = slot_q + CountW'(1);
              res_valid_o       = 1'b1;
              res_o.record_kind = RecVertex;
              res_o.value       = ValueW'(word_i);
              res_o.vertex_slot = slot_q;
              res_o.status      = last && (vleft_dec != '0);
            end
          end else begin
            // Count word opens a polygon
            if (!(&poly_cnt_q)) begin
              poly_cnt_d = poly_cnt_q + POLY_COUNT_BITS'(1);
            end
            vleft_d           = count;
            slot_d            = '0;
            res_valid_o       = 1'b1;
            res_o.record_kind = RecHeader;
            res_o.value       = ValueW'(count);
            res_o.poly_flags  = word_i[WordW-1:CountW];
            res_o.status      = last && (count != '0);
          end
          res_o.polygon_number = poly_num;
          res_o.is_bone        = (cfg_i.poly_kind == KindBone);
          res_o.last_in_chunk  = last;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= ChunkBytesReset;
      vleft_q      <= '0;
      slot_q       <= '0;
      high_half_q  <= '0;
      high_pend_q  <= 1'b0;
      poly_cnt_q   <= '0;
      chunk_done_q <= 1'b0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      vleft_q      <= vleft_d;
      slot_q       <= slot_d;
      high_half_q  <= high_half_d;
      high_pend_q  <= high_pend_d;
      poly_cnt_q   <= poly_cnt_d;
      chunk_done_q <= chunk_done_d;
    end
  end

endmodule

/* design/pcip_out_stage.sv */
// Output register of the parser: holds one record until the sink takes it.
// Depends on pcip_pkg and pcip_out_if.
module pcip_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                proc_en_i,
  input  logic                res_valid_i,
  input  pcip_pkg::pcip_res_t res_i,
  output logic                free_o,
  pcip_out_if.source          out_if
);
  import pcip_pkg::*;

  logic      valid_q, valid_d;
  pcip_res_t res_q;

  // Register can load when empty or being drained this cycle
  assign free_o  = !valid_q || out_if.ready;
  assign valid_d = free_o ? (proc_en_i && res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && proc_en_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_if.valid          = valid_q;
  assign out_if.record_kind    = res_q.record_kind;
  assign out_if.value          = res_q.value;
  assign out_if.poly_flags     = res_q.poly_flags;
  assign out_if.vertex_slot    = res_q.vertex_slot;
  assign out_if.polygon_number = res_q.polygon_number;
  assign out_if.is_bone        = res_q.is_bone;
  assign out_if.last_in_chunk  = res_q.last_in_chunk;
  assign out_if.status         = res_q.status;

endmodule

/* design/polygon_chunk_index_parser.sv */
// Polygon chunk index parser: takes one 16-bit chunk word per clock while the output
// is not stalled, and emits polygon header and vertex index records. Sustained rate
// is one word per cycle while the sink holds ready; an accepted word waits in the input
// register, is parsed, and its record loads the output register. The rate rests on the
// parse state (byte count, vertex count, slot, long-index half) updating once per word between the two registers.
// Output ready reaches input ready combinationally, through a short and-or path.
// Configuration writes take effect on the next processed word. Depends on pcip_pkg,
// pcip_if, pcip_in_stage, pcip_parser and pcip_out_stage.
module polygon_chunk_index_parser #(
  parameter int unsigned POLY_COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcip_pkg::CfgDataW-1:0] cfg_wdata_i,
  pcip_in_if.sink                       in_if,
  pcip_out_if.source                    out_if
);
  import pcip_pkg::*;

  pcip_cfg_t        cfg_q;
  logic             word_valid;
  logic [WordW-1:0] word;
  logic             out_free;
  logic             proc_en;
  logic             res_valid;
  pcip_res_t        res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_bytes <= ChunkBytesReset;
      cfg_q.poly_kind   <= KindFace;
    end else if (cfg_we_i) begin
      unique case (pcip_cfg_idx_e'(cfg_idx_i))
        CfgChunkBytes: cfg_q.chunk_bytes <= cfg_wdata_i[ChunkBytesW-1:0];
        CfgPolyKind:   cfg_q.poly_kind   <= cfg_wdata_i[KindW-1:0];
        default: ;
      endcase
    end
  end

  // A held word is processed whenever the output register can take its record
  assign proc_en = word_valid && out_free;

  pcip_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .proc_en_i    (proc_en),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  pcip_parser #(
    .POLY_COUNT_BITS (POLY_COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_en_i   (proc_en),
    .word_i      (word),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pcip_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_en_i   (proc_en),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_if      (out_if)
  );

endmodule
